FILE: src/decimal_digit_serial_arith_defines.svh
// assertion macros shared by the decimal digit-serial arithmetic block
`ifndef DECIMAL_DIGIT_SERIAL_ARITH_DEFINES_SVH
`define DECIMAL_DIGIT_SERIAL_ARITH_DEFINES_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define DDSA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication check failed");

// antecedent implies consequent in the next cycle
`define DDSA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define DDSA_ASSERT_IMP(lbl, ante, cons)
`define DDSA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: src/ddsa_pkg.sv
// shared types, constants and helpers for the decimal digit-serial arithmetic block
package ddsa_pkg;

    // operand and running value width
    localparam int OPERAND_BITS = 16;
    // fixed field widths
    localparam int DIGIT_W = 4;
    localparam int CARRY_W = 16;
    localparam int KIND_W  = 2;

    // working width: running value times ten plus a digit
    localparam int U_W = OPERAND_BITS + 4;

    // reciprocal of ten, exact for every value below 2**U_W
    localparam int RECIP_S = U_W + 4;
    localparam int RECIP_W = U_W + 1;
    localparam logic [RECIP_W-1:0] RECIP_TEN =
        RECIP_W'(((64'd1 << RECIP_S) + 64'd9) / 64'd10);
    localparam int PROD_W = U_W + RECIP_W;
    localparam int QUOT_W = PROD_W - RECIP_S;

    // stream word layouts
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 3;
    localparam int M_BITS    = DIGIT_W + CARRY_W;
    localparam int M_TDATA_W = ((M_BITS + 7) / 8) * 8;

    typedef logic [OPERAND_BITS-1:0] operand_t;
    typedef logic [U_W-1:0]          wide_t;
    typedef logic [DIGIT_W-1:0]      digit_t;
    typedef logic [KIND_W-1:0]       kind_t;

    localparam operand_t OPERAND_MAX = '1;

    // operation codes
    localparam kind_t KIND_DIV = 2'd0;
    localparam kind_t KIND_MUL = 2'd1;
    localparam kind_t KIND_SUB = 2'd2;

    // datapath operations issued by the controller
    typedef enum logic [2:0] {
        DP_NONE,
        DP_LOAD,
        DP_PREP,
        DP_SAT9,
        DP_DSTEP,
        DP_DFIN,
        DP_MMUL,
        DP_MFIN
    } dp_op_t;

    typedef struct packed {
        dp_op_t      op;
        logic [1:0]  step;
        logic        emit;
    } ddsa_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  ge_nine;
        logic  rem_lt_div;
    } ddsa_status_t;

    // clamp a working value to the operand range
    function automatic operand_t sat_operand(input wide_t v);
        sat_operand = (v > wide_t'(OPERAND_MAX)) ? OPERAND_MAX : operand_t'(v);
    endfunction

endpackage

FILE: src/ddsa_ctrl.sv
// controller state machine sequencing one digit through the datapath
module ddsa_ctrl import ddsa_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  ddsa_status_t st,
    output ddsa_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_CHECK,
        S_DIV,
        S_DFIN,
        S_MUL,
        S_MFIN,
        S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] step_reg, step_next;
    logic       s_tready_reg;
    logic       m_tvalid_reg, m_tvalid_next;

    // next state and datapath command
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd.op     = DP_NONE;
        cmd.step   = step_reg;
        cmd.emit   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                // load only on a real handshake
                if (s_tvalid && s_tready_reg) begin
                    cmd.op     = DP_LOAD;
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                cmd.op = DP_PREP;
                if (st.kind == KIND_DIV) begin
                    state_next = S_CHECK;
                end else if (st.kind == KIND_MUL) begin
                    state_next = S_MUL;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_CHECK: begin
                if (st.ge_nine) begin
                    cmd.op     = DP_SAT9;
                    state_next = S_OUT;
                end else begin
                    step_next  = 2'd3;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.op    = DP_DSTEP;
                step_next = step_reg - 2'd1;
                if (step_reg == 2'd0) begin
                    state_next = S_DFIN;
                end
            end
            S_DFIN: begin
                cmd.op     = DP_DFIN;
                state_next = S_OUT;
            end
            S_MUL: begin
                cmd.op     = DP_MMUL;
                state_next = S_MFIN;
            end
            S_MFIN: begin
                cmd.op     = DP_MFIN;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid: set on emit, cleared when taken
    always_comb begin
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // state and registered handshake outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            step_reg     <= 2'd0;
            s_tready_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            s_tready_reg <= (state_next == S_IDLE);
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

FILE: src/ddsa_dp.sv
// datapath: running value, divide steps, multiply by reciprocal, subtract
module ddsa_dp import ddsa_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CARRY_W-1:0]   cfg_data,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  ddsa_cmd_t            cmd,
    output ddsa_status_t         st,
    output logic [M_TDATA_W-1:0] m_tdata
);

    operand_t             op_reg;
    operand_t             rc_reg;
    kind_t                kind_reg;
    digit_t               da_reg;
    digit_t               db_reg;
    wide_t                u_reg;
    wide_t                nine_reg;
    digit_t               q_reg;
    logic [PROD_W-1:0]    prod_reg;
    digit_t               digit_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    operand_t             n_eff;
    wide_t                dvs;
    logic [QUOT_W-1:0]    quo;
    wide_t                quo_x10;
    wide_t                mul_rem;
    logic                 borrow_in;
    logic signed [5:0]    sub_diff;
    logic signed [5:0]    sub_fix;

    // zero divisor divides as one
    assign n_eff = (op_reg == '0) ? operand_t'(1) : op_reg;

    // shifted divisor for the current restoring step
    assign dvs = wide_t'(n_eff) << cmd.step;

    // quotient by ten and remainder digit
    assign quo     = prod_reg[PROD_W-1:RECIP_S];
    assign quo_x10 = (wide_t'(quo) << 3) + (wide_t'(quo) << 1);
    assign mul_rem = u_reg - quo_x10;

    // subtract with borrow
    assign borrow_in = (rc_reg != '0);
    assign sub_diff  = $signed({2'b00, da_reg}) - $signed({2'b00, db_reg})
                       - $signed({5'b00000, borrow_in});
    assign sub_fix   = (sub_diff < 0) ? (sub_diff + 6'sd10) : sub_diff;

    // status to controller
    assign st.kind       = kind_reg;
    assign st.ge_nine    = (u_reg >= nine_reg);
    assign st.rem_lt_div = (u_reg < wide_t'(n_eff));

    // configuration and running value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg <= operand_t'(1);
            rc_reg <= '0;
        end else begin
            if (cfg_we) begin
                op_reg <= operand_t'(cfg_data);
            end
            case (cmd.op)
                DP_LOAD: begin
                    if (s_tuser[2]) begin
                        rc_reg <= '0;
                    end
                end
                DP_PREP: begin
                    if (kind_reg == KIND_SUB) begin
                        rc_reg <= (sub_diff < 0) ? operand_t'(1) : '0;
                    end
                end
                DP_SAT9: rc_reg <= sat_operand(u_reg - nine_reg);
                DP_DFIN: rc_reg <= operand_t'(u_reg);
                DP_MFIN: rc_reg <= sat_operand(wide_t'(quo));
                default: ;
            endcase
        end
    end

    // working registers of the datapath
    always_ff @(posedge aclk) begin
        case (cmd.op)
            DP_LOAD: begin
                kind_reg <= s_tuser[1:0];
                da_reg   <= s_tdata[3:0];
                db_reg   <= s_tdata[7:4];
            end
            DP_PREP: begin
                case (kind_reg)
                    KIND_DIV: begin
                        u_reg    <= (wide_t'(rc_reg) << 3) + (wide_t'(rc_reg) << 1)
                                    + wide_t'(da_reg);
                        nine_reg <= (wide_t'(n_eff) << 3) + wide_t'(n_eff);
                        q_reg    <= '0;
                    end
                    KIND_MUL: begin
                        u_reg <= wide_t'(op_reg) * wide_t'(da_reg) + wide_t'(rc_reg);
                    end
                    KIND_SUB: begin
                        digit_reg <= sub_fix[3:0];
                    end
                    default: begin
                        digit_reg <= '0;
                    end
                endcase
            end
            DP_SAT9: begin
                digit_reg <= digit_t'(9);
            end
            DP_DSTEP: begin
                if (u_reg >= dvs) begin
                    u_reg           <= u_reg - dvs;
                    q_reg[cmd.step] <= 1'b1;
                end
            end
            DP_DFIN: begin
                digit_reg <= q_reg;
            end
            DP_MMUL: begin
                prod_reg <= PROD_W'(u_reg) * PROD_W'(RECIP_TEN);
            end
            DP_MFIN: begin
                digit_reg <= mul_rem[3:0];
            end
            default: ;
        endcase
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= M_TDATA_W'({CARRY_W'(rc_reg), digit_reg});
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule

FILE: src/decimal_digit_serial_arith.sv
// top level of the decimal digit-serial arithmetic block
// divide loads, prepares, then saturates at nine or runs the four-step restoring divider;
// multiply loads, prepares, multiplies by the reciprocal of ten, finishes; subtract prepares
// the output register lets the next word enter while a result waits to be taken
// reset (synchronous, active low) sets operand_value to 1 and the running value to 0
`include "decimal_digit_serial_arith_defines.svh"

module decimal_digit_serial_arith import ddsa_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write: operand_value
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CARRY_W-1:0]   cfg_data,
    // input word
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // digit_a[3:0], digit_b[7:4]
    input  logic [S_TUSER_W-1:0] s_tuser,   // kind[1:0], first[2]
    // result word
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // digit_out[3:0], carry_out[19:4], zero pad
);

    ddsa_cmd_t    cmd;
    ddsa_status_t st;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    ddsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ddsa_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .st       (st),
        .m_tdata  (m_tdata)
    );

    // one item in flight at a time
    `DDSA_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)
    // a result is only written into a free or draining output slot
    `DDSA_ASSERT_IMP(a_slot_free, cmd.emit, !m_tvalid || m_tready)
    // restoring division leaves a remainder below the divisor
    `DDSA_ASSERT_IMP(a_rem_below, cmd.op == DP_DFIN, st.rem_lt_div)

endmodule

FILE: bench/decimal_digit_serial_arith_tb.sv
// testbench for the decimal digit-serial arithmetic block with its own digit predictor
module decimal_digit_serial_arith_tb;
    import ddsa_pkg::*;

    // unused operation code, only ever sent as noise
    localparam kind_t KIND_NONE = 2'd3;
    // cycles to let pass after the last word before touching the register
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int PHASE_WORDS   = 104;
    localparam int PHASE_COUNT   = 13;

    typedef struct packed {
        digit_t   digit;
        operand_t carry;
    } digit_result_t;

    // predicts each result word and checks the words coming back
    class digit_predictor;
        operand_t      divisor_multiplier;
        operand_t      running_value;
        digit_result_t expected_words[$];
        int            mismatches;
        int            checked;
        int            accepted;
        int            per_kind[4];

        function new();
            divisor_multiplier = 16'd1;
            running_value      = '0;
            mismatches         = 0;
            checked            = 0;
            accepted           = 0;
            per_kind           = '{0, 0, 0, 0};
        endfunction

        function void set_operand(operand_t v);
            divisor_multiplier = v;
        endfunction

        function operand_t clamp_operand(int unsigned v);
            return (v > int'(OPERAND_MAX)) ? OPERAND_MAX : operand_t'(v);
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // work out the result of one accepted input word
        function void note_digit(kind_t k, digit_t a, digit_t b, logic first);
            int unsigned   rv, av, ov, n, u, q, c;
            int            diff, sa, sb;
            digit_result_t r;
            if (first)
                running_value = '0;
            rv = running_value;
            av = a;
            ov = divisor_multiplier;
            r.digit = '0;
            case (k)
                KIND_DIV: begin
                    // an operand of zero divides as one; quotient saturates at nine
                    n = (ov == 0) ? 1 : ov;
                    u = rv * 10 + av;
                    q = u / n;
                    if (q > 9)
                        q = 9;
                    running_value = clamp_operand(u - q * n);
                    r.digit = digit_t'(q);
                end
                KIND_MUL: begin
                    u = ov * av + rv;
                    c = u / 10;
                    r.digit = digit_t'(u - c * 10);
                    running_value = clamp_operand(c);
                end
                KIND_SUB: begin
                    // any nonzero running value is a borrow of one
                    sa = a;
                    sb = b;
                    diff = sa - sb - ((rv != 0) ? 1 : 0);
                    running_value = '0;
                    if (diff < 0) begin
                        diff += 10;
                        running_value = 16'd1;
                    end
                    r.digit = digit_t'(diff);
                end
                default: ;
            endcase
            r.carry = running_value;
            expected_words.push_back(r);
            accepted++;
            per_kind[k]++;
        endfunction

        // compare one result word with the oldest prediction
        function void check_word(logic [M_TDATA_W-1:0] w);
            digit_result_t exp_r;
            digit_t        got_digit;
            operand_t      got_carry;
            got_digit = w[DIGIT_W-1:0];
            got_carry = w[DIGIT_W +: CARRY_W];
            checked++;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: digit %0d carry %0d",
                             got_digit, got_carry);
                return;
            end
            exp_r = expected_words.pop_front();
            if (got_digit !== exp_r.digit || got_carry !== exp_r.carry) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on word %0d: expected %0d carry %0d, got %0d carry %0d",
                             checked, exp_r.digit, exp_r.carry, got_digit, got_carry);
            end
        endfunction

        function void flag_leftover();
            if (expected_words.size() != 0) begin
                $display("%0d predicted words never arrived", expected_words.size());
                mismatches += expected_words.size();
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CARRY_W-1:0]   cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // digit_a[3:0], digit_b[7:4]
    logic [S_TUSER_W-1:0] s_tuser = '0;   // kind[1:0], first[2]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // digit_out[3:0], carry_out[19:4], zero pad

    digit_predictor predictor = new();
    int burst_left   = 0;
    int settings     = 0;
    int stall_mode   = 0;
    int stall_span   = 0;
    int stall_tick   = 0;

    decimal_digit_serial_arith uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // receiver back-pressure, switching between stall patterns
    always @(posedge aclk) begin
        if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(16, 96);
        end
        stall_span--;
        stall_tick++;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= (stall_tick % 4 == 0);
            default: m_tready <= (stall_tick % 14 >= 12);
        endcase
    end

    // word monitor on both streams
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                predictor.check_word(m_tdata);
            if (s_tvalid && s_tready)
                predictor.note_digit(kind_t'(s_tuser[1:0]), s_tdata[3:0], s_tdata[7:4],
                                     s_tuser[2]);
        end
    end

    // mostly decimal digits, sometimes an out-of-range nibble
    function automatic digit_t rand_digit();
        if ($urandom_range(0, 99) < 94)
            return digit_t'($urandom_range(0, 9));
        return digit_t'($urandom_range(10, 15));
    endfunction

    function automatic operand_t phase_operand(int p);
        case (p)
            0: return 16'd1;
            1: return 16'd0;
            2: return 16'hFFFF;
            3: return 16'd7;
            4: return 16'd239;
            5: return 16'd25;
            6: return 16'd5;
            7: return 16'd2;
            8: return 16'd10;
            9: return 16'h8000;
            10: return 16'd9999;
            11: return operand_t'($urandom_range(3, 400));
            default: return operand_t'($urandom_range(1, 65535));
        endcase
    endfunction

    // send one input word, with bursts and gaps on the sender side
    task automatic push_digit(kind_t k, digit_t a, digit_t b, logic first);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tuser  <= {first, k};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // wait until every predicted word has come back or the drain limit runs out, then let the block settle
    task automatic drain_results();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (predictor.pending() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_operand(operand_t v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        predictor.set_operand(v);
        settings++;
    endtask

    // one pass of digits; a broken pass may drop the first flag and mixes in other kinds
    task automatic run_pass(kind_t k, int len, bit broken);
        kind_t kk;
        logic  f;
        for (int i = 0; i < len; i++) begin
            kk = k;
            f  = (i == 0);
            if (broken) begin
                if (i == 0 && $urandom_range(0, 1) == 1)
                    f = 1'b0;
                if ($urandom_range(0, 5) == 0)
                    kk = kind_t'($urandom_range(0, 3));
            end
            push_digit(kk, rand_digit(), rand_digit(), f);
        end
    endtask

    // run limit
    initial begin
        #6000000;
        $display("DONE: errors detected");
        $finish;
    end

    // stimulus
    initial begin
        int start, sel;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: small divisor, each operation and the corner cases
        write_operand(16'd7);
        push_digit(KIND_DIV, 4'd1, 4'd0, 1'b1);
        push_digit(KIND_DIV, 4'd0, 4'd9, 1'b0);
        push_digit(KIND_DIV, 4'd9, 4'd0, 1'b0);
        push_digit(KIND_DIV, 4'd15, 4'd15, 1'b0);
        push_digit(KIND_MUL, 4'd9, 4'd0, 1'b1);
        push_digit(KIND_MUL, 4'd9, 4'd0, 1'b0);
        push_digit(KIND_MUL, 4'd0, 4'd0, 1'b0);
        push_digit(KIND_SUB, 4'd0, 4'd9, 1'b1);
        push_digit(KIND_SUB, 4'd5, 4'd5, 1'b0);
        push_digit(KIND_SUB, 4'd15, 4'd0, 1'b0);
        push_digit(KIND_SUB, 4'd0, 4'd15, 1'b0);
        push_digit(KIND_NONE, 4'd3, 4'd4, 1'b0);
        push_digit(KIND_NONE, 4'd9, 4'd9, 1'b1);
        drain_results();

        // zero divisor and saturated quotients
        write_operand(16'd0);
        push_digit(KIND_DIV, 4'd5, 4'd0, 1'b1);
        push_digit(KIND_DIV, 4'd9, 4'd0, 1'b0);
        push_digit(KIND_DIV, 4'd12, 4'd0, 1'b0);
        push_digit(KIND_DIV, 4'd0, 4'd0, 1'b0);
        push_digit(KIND_MUL, 4'd7, 4'd0, 1'b0);
        drain_results();

        // largest multiplier: carry saturation, then a divide on top of it
        write_operand(16'hFFFF);
        push_digit(KIND_MUL, 4'd15, 4'd0, 1'b1);
        push_digit(KIND_MUL, 4'd9, 4'd0, 1'b0);
        push_digit(KIND_DIV, 4'd0, 4'd0, 1'b0);
        push_digit(KIND_DIV, 4'd9, 4'd0, 1'b0);
        push_digit(KIND_SUB, 4'd3, 4'd2, 1'b0);

        // random phases, one operand setting each
        for (int p = 0; p < PHASE_COUNT; p++) begin
            drain_results();
            write_operand(phase_operand(p));
            start = predictor.accepted;
            while (predictor.accepted - start < PHASE_WORDS) begin
                sel = $urandom_range(0, 99);
                if (sel < 80)
                    run_pass(kind_t'($urandom_range(0, 2)), $urandom_range(1, 20), 1'b0);
                else if (sel < 92)
                    run_pass(kind_t'($urandom_range(0, 2)), $urandom_range(1, 12), 1'b1);
                else
                    push_digit(kind_t'($urandom_range(0, 3)), digit_t'($urandom_range(0, 15)),
                               digit_t'($urandom_range(0, 15)), logic'($urandom_range(0, 1)));
            end
        end

        drain_results();
        predictor.flag_leftover();
        $display("covered %0d divide, %0d multiply, %0d subtract and %0d unused-kind digits",
                 predictor.per_kind[0], predictor.per_kind[1], predictor.per_kind[2],
                 predictor.per_kind[3]);
        $display("checked %0d result words across %0d operand settings",
                 predictor.checked, settings);
        if (predictor.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
